// ----- rtl/mebt_pkg.sv -----
// mebt_pkg: shared constants, types and saturating fixed-point helpers
// for the eight-lane escape-time engine; no dependencies
package mebt_pkg;

	localparam int LANES     = 8;
	localparam int FRAC_BITS = 52;
	localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int IDX_W     = $clog2(65536 + LANES);

	// configuration register indexes
	localparam logic [2:0] REG_START_REAL = 3'd0;
	localparam logic [2:0] REG_STEP_REAL  = 3'd1;
	localparam logic [2:0] REG_START_IMAG = 3'd2;
	localparam logic [2:0] REG_STEP_IMAG  = 3'd3;
	localparam logic [2:0] REG_MAX_ITER   = 3'd4;
	localparam logic [2:0] REG_BAILOUT    = 3'd5;
	localparam logic [2:0] REG_TOLERANCE  = 3'd6;
	localparam logic [2:0] REG_SAVE_PER   = 3'd7;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	typedef struct packed {
		logic signed [63:0] start_real;
		logic signed [63:0] step_real;
		logic signed [63:0] start_imag;
		logic signed [63:0] step_imag;
		logic [31:0]        max_iterations;
		logic [62:0]        bailout_limit;
		logic [62:0]        period_tolerance;
		logic [15:0]        save_period;
	} cfg_t;

	typedef struct packed {
		logic go;
		logic clr;
	} lane_ctl_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] c_real;
		logic signed [63:0] c_imag;
		logic [31:0]        count;
		logic [62:0]        mag;
	} lane_res_t;

	// clamp a 128-bit value to the signed 64-bit range
	function automatic logic signed [63:0] sat128(input logic signed [127:0] v);
		if ((&v[127:63]) || !(|v[127:63]))
			return v[63:0];
		return v[127] ? S64_MIN : S64_MAX;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	// floor shift of an exact product, one less fraction bit for the doubled term
	function automatic logic signed [63:0] fix_sh(input logic signed [127:0] p,
		input logic dbl);
		logic signed [127:0] t;
		t = dbl ? (p >>> (FRAC_BITS - 1)) : (p >>> FRAC_BITS);
		return sat128(t);
	endfunction

endpackage

// ----- rtl/mebt_if.sv -----
// mebt_pix_if / mebt_res_if: valid-ready channels of the escape-time engine
// depends on mebt_pkg
interface mebt_pix_if import mebt_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [15:0] first_column;
	logic [15:0] row;
	modport source(output valid, output first_column, output row, input ready);
	modport sink(input valid, input first_column, input row, output ready);
endinterface

interface mebt_res_if import mebt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [63:0] c_real_out;
	logic signed [63:0] c_imag_out;
	logic [31:0]        iteration_count;
	logic [62:0]        final_magnitude_sq;
	logic               lane_last;
	modport source(output valid, output c_real_out, output c_imag_out,
		output iteration_count, output final_magnitude_sq, output lane_last, input ready);
	modport sink(input valid, input c_real_out, input c_imag_out,
		input iteration_count, input final_magnitude_sq, input lane_last, output ready);
endinterface

// ----- rtl/mebt_mul.sv -----
// mebt_mul: multi-cycle exact signed 64x64 multiplier, one 32x32 partial a cycle
// depends on mebt_pkg
module mebt_mul import mebt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  a,
	input  logic signed [63:0]  b,
	output logic                done,
	output logic signed [127:0] prod
);

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic         busy_q;
	logic [2:0]   cnt_q;
	logic [63:0]  p_s1;
	logic [1:0]   off_s1;
	logic [127:0] acc_q;
	logic [127:0] addend;
	logic [31:0]  opa, opb;
	logic         done_q;

	always_comb begin
		opa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		opb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		case (off_s1)
			2'd0:    addend = {64'd0, p_s1};
			2'd1:    addend = {32'd0, p_s1, 32'd0};
			default: addend = {p_s1, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[63] ? 64'(-a) : 64'(a);
			ub_q  <= b[63] ? 64'(-b) : 64'(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				p_s1   <= opa * opb;
				off_s1 <= (cnt_q == 3'd0) ? 2'd0 : ((cnt_q == 3'd3) ? 2'd2 : 2'd1);
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + addend;
			if (cnt_q == 3'd5)
				prod <= neg_q ? signed'(-acc_q) : signed'(acc_q);
		end
	end

	assign done = done_q;

endmodule

// ----- rtl/mebt_lane.sv -----
// mebt_lane: one pixel's orbit sequencer around a shared-in-lane multiplier
// depends on mebt_pkg, mebt_mul
module mebt_lane import mebt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [LANE_W-1:0] lane_id,
	input  lane_ctl_t         ctl,
	input  logic [15:0]       first_column,
	input  logic [15:0]       row,
	input  cfg_t              cfg,
	output lane_res_t         res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_FM   = 3'd3;
	localparam logic [2:0] ST_DIFF = 3'd4;
	localparam logic [2:0] ST_ERR  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam logic [2:0] OP_CR   = 3'd0;
	localparam logic [2:0] OP_CI   = 3'd1;
	localparam logic [2:0] OP_ZR2  = 3'd2;
	localparam logic [2:0] OP_ZI2  = 3'd3;
	localparam logic [2:0] OP_ZRZI = 3'd4;
	localparam logic [2:0] OP_DR2  = 3'd5;
	localparam logic [2:0] OP_DI2  = 3'd6;

	logic [2:0]          state_q, op_q;
	logic                mul_go_q;
	logic signed [63:0]  mul_a_q, mul_b_q;
	logic                mul_done;
	logic signed [127:0] prod;
	logic [15:0]         row_q;
	logic signed [63:0]  cr_q, ci_q, zr_q, zi_q, sr_q, si_q;
	logic signed [63:0]  zr2_q, zi2_q, diff_q, di_q, dr2_q, di2_q;
	logic [62:0]         fm_q;
	logic [31:0]         k_q;
	logic [15:0]         ph_q;
	logic [IDX_W-1:0]    idx;
	logic signed [63:0]  start_sel, coord_v, fix_n, fix_d, fm_sum, err_sum, dr_v;

	mebt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (prod)
	);

	always_comb begin
		idx       = IDX_W'(first_column) + IDX_W'(lane_id);
		start_sel = (op_q == OP_CR) ? cfg.start_real : cfg.start_imag;
		coord_v   = sat128(prod + {{64{start_sel[63]}}, start_sel});
		fix_n     = fix_sh(prod, 1'b0);
		fix_d     = fix_sh(prod, 1'b1);
		fm_sum    = sat_add(zr2_q, zi2_q);
		err_sum   = sat_add(dr2_q, di2_q);
		dr_v      = sat_sub(zr_q, sr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_CR;
			mul_go_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.go) begin
						mul_go_q <= 1'b1;
						op_q     <= OP_CR;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						case (op_q)
							OP_CR: begin
								mul_go_q <= 1'b1;
								op_q     <= OP_CI;
							end
							OP_CI:   state_q <= ST_CHK;
							OP_ZR2: begin
								mul_go_q <= 1'b1;
								op_q     <= OP_ZI2;
							end
							OP_ZI2:  state_q <= ST_FM;
							OP_ZRZI: state_q <= (cfg.save_period != '0) ? ST_DIFF : ST_CHK;
							OP_DR2: begin
								mul_go_q <= 1'b1;
								op_q     <= OP_DI2;
							end
							default: state_q <= ST_ERR;
						endcase
					end
				end
				ST_CHK: begin
					if (k_q >= cfg.max_iterations) begin
						state_q <= ST_DONE;
					end else begin
						mul_go_q <= 1'b1;
						op_q     <= OP_ZR2;
						state_q  <= ST_MUL;
					end
				end
				ST_FM: begin
					if (64'(fm_sum) >= {1'b0, cfg.bailout_limit}) begin
						state_q <= ST_DONE;
					end else begin
						mul_go_q <= 1'b1;
						op_q     <= OP_ZRZI;
						state_q  <= ST_MUL;
					end
				end
				ST_DIFF: begin
					mul_go_q <= 1'b1;
					op_q     <= OP_DR2;
					state_q  <= ST_MUL;
				end
				ST_ERR:  state_q <= (64'(err_sum) < {1'b0, cfg.period_tolerance}) ? ST_DONE : ST_CHK;
				ST_DONE: if (ctl.clr) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers follow the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				row_q   <= row;
				mul_a_q <= 64'(idx);
				mul_b_q <= cfg.step_real;
			end
			ST_MUL: begin
				if (mul_done) begin
					case (op_q)
						OP_CR: begin
							cr_q    <= coord_v;
							mul_a_q <= 64'(row_q);
							mul_b_q <= cfg.step_imag;
						end
						OP_CI: begin
							ci_q <= coord_v;
							zr_q <= cr_q;
							zi_q <= coord_v;
							k_q  <= 32'd1;
							ph_q <= '0;
							fm_q <= '0;
						end
						OP_ZR2: begin
							zr2_q   <= fix_n;
							mul_a_q <= zi_q;
							mul_b_q <= zi_q;
						end
						OP_ZI2:  zi2_q <= fix_n;
						OP_ZRZI: begin
							zr_q <= sat_add(diff_q, cr_q);
							zi_q <= sat_add(fix_d, ci_q);
							if (cfg.save_period == '0)
								k_q <= k_q + 32'd1;
						end
						OP_DR2: begin
							dr2_q   <= fix_n;
							mul_a_q <= di_q;
							mul_b_q <= di_q;
						end
						default: di2_q <= fix_n;
					endcase
				end
			end
			ST_CHK: begin
				mul_a_q <= zr_q;
				mul_b_q <= zr_q;
				if (cfg.save_period != '0) begin
					if (ph_q == '0) begin
						sr_q <= zr_q;
						si_q <= zi_q;
					end
					ph_q <= ({1'b0, ph_q} + 17'd1 == {1'b0, cfg.save_period}) ? '0 : ph_q + 16'd1;
				end
			end
			ST_FM: begin
				fm_q    <= fm_sum[62:0];
				diff_q  <= sat_sub(zr2_q, zi2_q);
				mul_a_q <= zr_q;
				mul_b_q <= zi_q;
			end
			ST_DIFF: begin
				mul_a_q <= dr_v;
				mul_b_q <= dr_v;
				di_q    <= sat_sub(zi_q, si_q);
			end
			ST_ERR: begin
				if (64'(err_sum) < {1'b0, cfg.period_tolerance})
					k_q <= cfg.max_iterations;
				else
					k_q <= k_q + 32'd1;
			end
			default: ;
		endcase
	end

	assign res.done   = (state_q == ST_DONE);
	assign res.c_real = cr_q;
	assign res.c_imag = ci_q;
	assign res.count  = k_q;
	assign res.mag    = fm_q;

endmodule

// ----- rtl/mandelbrot_escape_time_8_lanes_top.sv -----
// mandelbrot_escape_time_8_lanes_top: config registers, eight orbit lanes and
// the stage that merges their results into one result stream
// depends on mebt_pkg, mebt_if, mebt_lane
//
//  channel  dir  beat                                      when taken
//  pix      in   first_column, row                         valid & ready
//  res      out  c_real_out, c_imag_out, iteration_count,  valid & ready
//                final_magnitude_sq, lane_last
//  wr_*     in   wr_index, wr_data                         wr_en
//
// one item at a time: pix.ready is high only while the engine is empty
// each product is formed in the lane's 64x64 multiplier from 32x32 partials
// each lane forms its c with two products, then uses three products per
// iteration, five with the periodicity check
// an item lasts as long as the longest orbit of the eight lanes, plus the
// streaming of its eight results and any stall on res
// arst_n clears control state and loads the register defaults

module mandelbrot_escape_time_8_lanes_top import mebt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mebt_pix_if.sink    pix,
	mebt_res_if.source  res,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data
);

	localparam logic [1:0] TOP_IDLE = 2'd0;
	localparam logic [1:0] TOP_RUN  = 2'd1;
	localparam logic [1:0] TOP_EMIT = 2'd2;

	cfg_t              cfg_q;
	logic [1:0]        state_q;
	logic [LANE_W-1:0] sel_q;
	lane_ctl_t         ctl;
	lane_res_t         lane_res [LANES];
	logic [LANES-1:0]  lane_done;
	logic              in_beat, out_beat, last_lane;
	lane_res_t         cur;

	// configuration writes, expected only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_real       <= '0;
			cfg_q.step_real        <= '0;
			cfg_q.start_imag       <= '0;
			cfg_q.step_imag        <= '0;
			cfg_q.max_iterations   <= 32'd256;
			cfg_q.bailout_limit    <= 63'd1 << (FRAC_BITS + 2);
			cfg_q.period_tolerance <= '0;
			cfg_q.save_period      <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START_REAL: cfg_q.start_real       <= wr_data;
				REG_STEP_REAL:  cfg_q.step_real        <= wr_data;
				REG_START_IMAG: cfg_q.start_imag       <= wr_data;
				REG_STEP_IMAG:  cfg_q.step_imag        <= wr_data;
				REG_MAX_ITER:   cfg_q.max_iterations   <= wr_data[31:0];
				REG_BAILOUT:    cfg_q.bailout_limit    <= wr_data[62:0];
				REG_TOLERANCE:  cfg_q.period_tolerance <= wr_data[62:0];
				REG_SAVE_PER:   cfg_q.save_period      <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign in_beat   = pix.valid && pix.ready;
	assign out_beat  = res.valid && res.ready;
	assign last_lane = (sel_q == LANE_W'(LANES - 1));

	// go starts every lane on the accepted beat, clr frees them after the last result
	assign ctl.go  = in_beat;
	assign ctl.clr = out_beat && last_lane;

	genvar g;
	generate
		for (g = 0; g < LANES; g++) begin : g_lane
			mebt_lane u_lane (
				.clk          (clk),
				.arst_n       (arst_n),
				.lane_id      (LANE_W'(g)),
				.ctl          (ctl),
				.first_column (pix.first_column),
				.row          (pix.row),
				.cfg          (cfg_q),
				.res          (lane_res[g])
			);
			assign lane_done[g] = lane_res[g].done;
		end
	endgenerate

	// merge: wait for the slowest lane, then stream lane 0 first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_IDLE;
			sel_q   <= '0;
		end else begin
			unique case (state_q)
				TOP_IDLE: if (in_beat) state_q <= TOP_RUN;
				TOP_RUN: begin
					if (&lane_done) begin
						state_q <= TOP_EMIT;
						sel_q   <= '0;
					end
				end
				TOP_EMIT: begin
					if (out_beat) begin
						if (last_lane)
							state_q <= TOP_IDLE;
						else
							sel_q <= sel_q + LANE_W'(1);
					end
				end
				default: state_q <= TOP_IDLE;
			endcase
		end
	end

	assign cur = lane_res[sel_q];

	assign pix.ready              = (state_q == TOP_IDLE);
	assign res.valid              = (state_q == TOP_EMIT);
	assign res.c_real_out         = cur.c_real;
	assign res.c_imag_out         = cur.c_imag;
	assign res.iteration_count    = cur.count;
	assign res.final_magnitude_sq = cur.mag;
	assign res.lane_last          = last_lane;

endmodule

// ----- rtl/mebt_chk.sv -----
// mebt_chk: port-level checks on the escape-time engine, bound to its top level
// depends on mebt_pkg, mandelbrot_escape_time_8_lanes_top
module mebt_chk import mebt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        lane_last,
	input logic [31:0] iteration_count,
	input logic [63:0] c_real_out
);

	// no new item while results are still going out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(pix_ready && res_valid))
		else $error("input taken while results pending");

	// an accepted item closes the input side
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("input ready right after a beat");

	// the last lane's beat ends the item
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && lane_last |=> !res_valid)
		else $error("results continue past the last lane");

	// every orbit counts at least one
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> iteration_count != 32'd0)
		else $error("zero iteration count");

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(c_real_out)
			&& $stable(iteration_count))
		else $error("stalled result changed");

endmodule

bind mandelbrot_escape_time_8_lanes_top mebt_chk u_mebt_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.pix_valid       (pix.valid),
	.pix_ready       (pix.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.lane_last       (res.lane_last),
	.iteration_count (res.iteration_count),
	.c_real_out      (res.c_real_out)
);

// ----- tb/tb_mandelbrot_escape_time_8_lanes_top.sv -----
// tb_mandelbrot_escape_time_8_lanes_top: self-checking bench for the eight-lane escape-time
// engine, with its own fixed-point orbit predictor and random stalls on both channels
// depends on mebt_pkg, mebt_if and the engine's top level
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time_8_lanes_top;
	import mebt_pkg::*;

	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam logic [62:0] MAG_ALL = {63{1'b1}};
	localparam int CYCLE_LIMIT = 20000000;
	localparam int SETTLE_CYC  = 64;
	localparam int HOLD_CYC    = 3000;
	localparam int RAND_PHASES = 11;
	localparam int RAND_ITEMS  = 18;

	// one lane result as it leaves the engine
	typedef struct {
		logic signed [63:0] c_re;
		logic signed [63:0] c_im;
		logic [31:0]        count;
		logic [62:0]        mag;
		logic               last;
	} lane_beat_t;

	// directed row: setting to use, pixel, and the fields readable at a glance
	typedef struct {
		int                 setting;
		logic [15:0]        col;
		logic [15:0]        row;
		bit                 fix_c;
		logic signed [63:0] c_re;
		logic signed [63:0] c_im;
		bit                 fix_count;
		logic [31:0]        count;
		bit                 fix_mag;
		logic [62:0]        mag;
	} pixel_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [63:0] wr_data = '0;

	mebt_pix_if pix_ch ();
	mebt_res_if res_ch ();

	mandelbrot_escape_time_8_lanes_top DUT (
		.clk(clk), .arst_n(arst_n), .pix(pix_ch.sink), .res(res_ch.source),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #5 clk = ~clk;

	cfg_t       regs_now;        // mirror of the engine's registers
	lane_beat_t pending_lanes[$];
	int         failures = 0;
	int         beats_checked = 0;
	int         pixels_sent = 0;
	int         settings_used = 0;
	int         cycles = 0;
	bit         hold_req = 1'b0; // ask the result side for one long hold-off
	bit         calm = 1'b0;     // no idling on either side

	initial begin
		pix_ch.valid = 1'b0;
		pix_ch.first_column = '0;
		pix_ch.row = '0;
		res_ch.ready = 1'b0;
	end

	// ---------------- fixed-point predictor ----------------

	function automatic logic signed [63:0] clamp_s64(input logic signed [127:0] v);
		if (v > $signed({64'd0, S64_MAX}))
			return S64_MAX;
		if (v < $signed({{64{1'b1}}, S64_MIN}))
			return S64_MIN;
		return v[63:0];
	endfunction

	function automatic logic signed [127:0] widen(input logic signed [63:0] a);
		return $signed({{64{a[63]}}, a});
	endfunction

	// exact product, floor shift, clamp
	function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
		input logic signed [63:0] b, input int sh);
		logic signed [127:0] p;
		p = widen(a) * widen(b);
		return clamp_s64(p >>> sh);
	endfunction

	function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		return clamp_s64(widen(a) + widen(b));
	endfunction

	function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		return clamp_s64(widen(a) - widen(b));
	endfunction

	// start + idx*step, exact then clamped once
	function automatic logic signed [63:0] grid_point(input logic signed [63:0] start,
		input logic [16:0] idx, input logic signed [63:0] step);
		logic signed [127:0] p;
		p = $signed({111'd0, idx}) * widen(step) + widen(start);
		return clamp_s64(p);
	endfunction

	// one orbit: count at escape (or limit) and last squared magnitude
	task automatic orbit(input logic signed [63:0] cr, input logic signed [63:0] ci,
		output logic [31:0] count, output logic [62:0] mag);
		logic signed [63:0] zr, zi, sr, si, zr2, zi2, fm, nr, ni, dr, di, err;
		logic [32:0] k;
		zr = cr;
		zi = ci;
		sr = '0;
		si = '0;
		fm = '0;
		for (k = 1; k < {1'b0, regs_now.max_iterations}; k++) begin
			zr2 = q_mul(zr, zr, FRAC_BITS);
			zi2 = q_mul(zi, zi, FRAC_BITS);
			if (regs_now.save_period != 0 && ((k - 1) % regs_now.save_period) == 0) begin
				sr = zr;
				si = zi;
			end
			fm = q_add(zr2, zi2);
			if (!($unsigned(fm) < {1'b0, regs_now.bailout_limit}))
				break;
			nr = q_add(q_sub(zr2, zi2), cr);
			ni = q_add(q_mul(zr, zi, FRAC_BITS - 1), ci);
			zr = nr;
			zi = ni;
			if (regs_now.save_period != 0) begin
				dr = q_sub(zr, sr);
				di = q_sub(zi, si);
				err = q_add(q_mul(dr, dr, FRAC_BITS), q_mul(di, di, FRAC_BITS));
				if ($unsigned(err) < {1'b0, regs_now.period_tolerance}) begin
					k = {1'b0, regs_now.max_iterations};
					break;
				end
			end
		end
		count = k[31:0];
		mag = fm[62:0];
	endtask

	// all eight lane results of one pixel beat, queued in lane order
	task automatic queue_pixel_lanes(input pixel_row_t r);
		lane_beat_t b;
		logic signed [63:0] ci;
		ci = grid_point(regs_now.start_imag, {1'b0, r.row}, regs_now.step_imag);
		for (int i = 0; i < LANES; i++) begin
			b.c_re = grid_point(regs_now.start_real, {1'b0, r.col} + 17'(i),
				regs_now.step_real);
			b.c_im = ci;
			orbit(b.c_re, b.c_im, b.count, b.mag);
			if (r.fix_c) begin
				b.c_re = r.c_re;
				b.c_im = r.c_im;
			end
			if (r.fix_count)
				b.count = r.count;
			if (r.fix_mag)
				b.mag = r.mag;
			b.last = (i == LANES - 1);
			pending_lanes.push_back(b);
		end
	endtask

	// ---------------- register settings ----------------

	function automatic cfg_t default_regs();
		cfg_t s;
		s = '0;
		s.max_iterations = 32'd256;
		s.bailout_limit = 63'd1 << 54;
		return s;
	endfunction

	function automatic cfg_t directed_regs(input int id);
		cfg_t s;
		s = default_regs();
		case (id)
			1: begin // limit of zero, coordinates at both rails
				s.start_real = S64_MIN;
				s.start_imag = S64_MAX;
				s.max_iterations = 32'd0;
			end
			2: begin // limit of one, huge steps saturate c
				s.step_real = S64_MAX;
				s.start_imag = S64_MIN;
				s.step_imag = S64_MIN;
				s.max_iterations = 32'd1;
			end
			3: begin // largest limit, zero bailout escapes at once
				s.start_real = -2 * ONE_Q;
				s.step_real = ONE_Q >>> 8;
				s.start_imag = -ONE_Q;
				s.step_imag = ONE_Q >>> 8;
				s.max_iterations = '1;
				s.bailout_limit = '0;
			end
			4: begin // ordinary view of the set
				s.start_real = -2 * ONE_Q;
				s.step_real = ONE_Q >>> 6;
				s.start_imag = -ONE_Q - (ONE_Q >>> 1);
				s.step_imag = ONE_Q >>> 8;
				s.max_iterations = 32'd40;
			end
			5: begin // periodicity check on a realistic view
				s = directed_regs(4);
				s.max_iterations = 32'd60;
				s.period_tolerance = 63'(ONE_Q >>> 20);
				s.save_period = 16'd3;
			end
			6: begin // c = 0 with a huge tolerance: periodic at the first step
				s.max_iterations = 32'd100;
				s.period_tolerance = MAG_ALL;
				s.save_period = 16'd1;
			end
			7: begin // bailout reached only on saturation, widest snapshot interval
				s = directed_regs(4);
				s.max_iterations = 32'd30;
				s.bailout_limit = MAG_ALL;
				s.period_tolerance = 63'd1;
				s.save_period = 16'hFFFF;
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic cfg_t random_regs();
		cfg_t s;
		if ($urandom_range(0, 3) == 0) begin
			// any bits at all
			s.start_real = {$urandom, $urandom};
			s.step_real = {$urandom, $urandom};
			s.start_imag = {$urandom, $urandom};
			s.step_imag = {$urandom, $urandom};
		end else begin
			s.start_real = -2 * ONE_Q + ($signed(64'($urandom_range(0, 1023))) <<< 42);
			s.step_real = $signed(64'($urandom_range(1, 4095))) <<< 36;
			s.start_imag = -ONE_Q - ($signed(64'($urandom_range(0, 1023))) <<< 41);
			s.step_imag = $signed(64'($urandom)) >>> $urandom_range(0, 6);
			if ($urandom_range(0, 1))
				s.step_imag = s.step_imag >>> 8;
		end
		s.max_iterations = $urandom_range(0, 9) == 0 ? 32'd256 : 32'($urandom_range(1, 48));
		case ($urandom_range(0, 3))
			0: s.bailout_limit = {$urandom, $urandom};
			1: s.bailout_limit = 63'($urandom_range(1, 64)) << 50;
			default: s.bailout_limit = 63'd1 << 54;
		endcase
		case ($urandom_range(0, 3))
			0: s.save_period = '0;
			1: s.save_period = 16'($urandom);
			default: s.save_period = 16'($urandom_range(1, 20));
		endcase
		s.period_tolerance = $urandom_range(0, 2) == 0 ? 63'({$urandom, $urandom})
			: (63'($urandom) << $urandom_range(0, 30));
		return s;
	endfunction

	// ---------------- drivers ----------------

	// register beat; the caller lowers wr_en once the batch is done
	task automatic put_reg(input logic [2:0] idx, input logic [63:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	// stop offering pixels and let the engine empty out
	task automatic drain_engine();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_lanes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic load_regs(input cfg_t s);
		drain_engine();
		put_reg(REG_START_REAL, s.start_real);
		put_reg(REG_STEP_REAL, s.step_real);
		put_reg(REG_START_IMAG, s.start_imag);
		put_reg(REG_STEP_IMAG, s.step_imag);
		put_reg(REG_MAX_ITER, {32'd0, s.max_iterations});
		put_reg(REG_BAILOUT, {1'b0, s.bailout_limit});
		put_reg(REG_TOLERANCE, {1'b0, s.period_tolerance});
		put_reg(REG_SAVE_PER, {48'd0, s.save_period});
		wr_en <= 1'b0;
		regs_now = s;
		settings_used++;
	endtask

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	// offer one pixel beat and hold it until taken; called at a rising edge
	task automatic send_pixel(input pixel_row_t r, input int gap);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.first_column <= r.col;
		pix_ch.row <= r.row;
		queue_pixel_lanes(r);
		do
			@(posedge clk);
		while (!(pix_ch.valid && pix_ch.ready));
		pixels_sent++;
	endtask

	// ---------------- result side ----------------

	// random back-pressure, plus one long hold-off on request
	always @(posedge clk) begin
		int hold_left;
		int gap_left;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left = 0;
			gap_left = 0;
		end else if (hold_req) begin
			hold_req <= 1'b0;
			hold_left = HOLD_CYC;
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left--;
			res_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 20) begin
			gap_left = $urandom_range(0, 9) == 0 ? $urandom_range(20, 80)
				: $urandom_range(0, 2);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// compare every taken result beat with the oldest expectation
	always @(posedge clk) begin
		lane_beat_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_lanes.size() == 0) begin
				$error("result beat with nothing expected");
				failures++;
			end else begin
				e = pending_lanes.pop_front();
				beats_checked++;
				if (res_ch.c_real_out !== e.c_re) begin
					$error("c_real_out: expected %h, got %h", e.c_re, res_ch.c_real_out);
					failures++;
				end
				if (res_ch.c_imag_out !== e.c_im) begin
					$error("c_imag_out: expected %h, got %h", e.c_im, res_ch.c_imag_out);
					failures++;
				end
				if (res_ch.iteration_count !== e.count) begin
					$error("iteration_count: expected %0d, got %0d", e.count,
						res_ch.iteration_count);
					failures++;
				end
				if (res_ch.final_magnitude_sq !== e.mag) begin
					$error("final_magnitude_sq: expected %h, got %h", e.mag,
						res_ch.final_magnitude_sq);
					failures++;
				end
				if (res_ch.lane_last !== e.last) begin
					$error("lane_last: expected %b, got %b", e.last, res_ch.lane_last);
					failures++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	pixel_row_t plan[$];

	function automatic pixel_row_t row_of(input int setting, input logic [15:0] col,
		input logic [15:0] row);
		pixel_row_t r;
		r = '{default: '0};
		r.setting = setting;
		r.col = col;
		r.row = row;
		return r;
	endfunction

	initial begin
		pixel_row_t r;
		cfg_t s;
		int cur;

		regs_now = default_regs();

		// directed table, grouped by register setting
		// defaults after reset: c = 0 stays bounded, count = limit, magnitude 0
		r = row_of(0, 16'd0, 16'd0);
		r.fix_c = 1; r.fix_count = 1; r.count = 32'd256; r.fix_mag = 1;
		plan.push_back(r);
		r.col = 16'hFFFF; r.row = 16'hFFFF; plan.push_back(r);
		r.col = 16'h5555; r.row = 16'hAAAA; plan.push_back(r);
		// zero limit: no iteration, count 1, c pinned at the rails
		r = row_of(1, 16'h1234, 16'hFFFF);
		r.fix_c = 1; r.c_re = S64_MIN; r.c_im = S64_MAX;
		r.fix_count = 1; r.count = 32'd1; r.fix_mag = 1;
		plan.push_back(r);
		r.col = 16'hFFFF; r.row = 16'd0; plan.push_back(r);
		// limit of one, saturated c, column index past 16 bits
		r = row_of(2, 16'hFFFF, 16'hFFFF);
		r.fix_count = 1; r.count = 32'd1; r.fix_mag = 1;
		plan.push_back(r);
		r.col = 16'd0; r.row = 16'd1; plan.push_back(r);
		r.col = 16'hFFF9; r.row = 16'd0; plan.push_back(r);
		// zero bailout under the largest limit escapes on the first step
		r = row_of(3, 16'd0, 16'd0);
		r.fix_count = 1; r.count = 32'd1;
		plan.push_back(r);
		r.col = 16'd100; r.row = 16'd200; plan.push_back(r);
		// ordinary view, then with periodicity check
		plan.push_back(row_of(4, 16'd0, 16'd0));
		plan.push_back(row_of(4, 16'd64, 16'd192));
		plan.push_back(row_of(4, 16'd120, 16'd96));
		plan.push_back(row_of(4, 16'd184, 16'd300));
		plan.push_back(row_of(5, 16'd64, 16'd192));
		plan.push_back(row_of(5, 16'd88, 16'd150));
		plan.push_back(row_of(5, 16'd120, 16'd200));
		// c = 0 and huge tolerance: periodic right away, count = limit
		r = row_of(6, 16'd7, 16'd9);
		r.fix_c = 1; r.fix_count = 1; r.count = 32'd100; r.fix_mag = 1;
		plan.push_back(r);
		r.col = 16'hFFFF; r.row = 16'hFFFF; plan.push_back(r);
		// bailout at its top, so saturation alone ends an orbit
		plan.push_back(row_of(7, 16'd0, 16'd0));
		plan.push_back(row_of(7, 16'd110, 16'd190));
		plan.push_back(row_of(7, 16'hFFFF, 16'hFFFF));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed part
		cur = 0;
		foreach (plan[i]) begin
			if (plan[i].setting != cur) begin
				load_regs(directed_regs(plan[i].setting));
				cur = plan[i].setting;
			end
			calm = (i % 5 == 0);
			send_pixel(plan[i], pick_gap());
		end

		// random part: one fresh setting per phase
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			s = ph == RAND_PHASES - 1 ? default_regs() : random_regs();
			if (ph == RAND_PHASES - 1)
				s.max_iterations = 32'($urandom_range(20, 40));
			load_regs(s);
			calm = (ph % 4 == 3);
			if (ph == 2)
				hold_req = 1'b1; // engine fills up and stops taking pixels
			for (int n = 0; n < RAND_ITEMS; n++) begin
				r = row_of(0, 16'($urandom), 16'($urandom));
				// mostly inside the view, now and then anywhere in 16 bits
				if ($urandom_range(0, 3) != 0) begin
					r.col = 16'($urandom_range(0, 255));
					r.row = 16'($urandom_range(0, 255));
				end
				if (ph == 5 && n == RAND_ITEMS / 2) begin
					// sender waits for every outstanding result first
					pix_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending_lanes.size() != 0)
						@(posedge clk);
				end
				send_pixel(r, pick_gap());
			end
		end

		pix_ch.valid <= 1'b0;
		calm = 1'b0;
		while (pending_lanes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		$display("covered %0d pixel beats and %0d lane results under %0d register settings",
			pixels_sent, beats_checked, settings_used);
		$display("limits 0, 1, 256 and 2^32-1, saturated coordinates, periodicity check");
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mebt_pkg.sv
rtl/mebt_if.sv
rtl/mebt_mul.sv
rtl/mebt_lane.sv
rtl/mandelbrot_escape_time_8_lanes_top.sv
rtl/mebt_chk.sv
tb/tb_mandelbrot_escape_time_8_lanes_top.sv
